>>> design/gbu_pkg.sv
package gbu_pkg;

  // Default build sizes
  localparam int MAX_SRC_LOG   = 6;
  localparam int MAX_RATIO_LOG = 2;
  localparam int VALUE_WIDTH   = 32;

  // Fixed field widths of the channels
  localparam int FIELD_W    = 32;
  localparam int GRID_W     = 16;
  localparam int COORD_W    = 9;
  localparam int SRC_LOG_W  = 3;
  localparam int RATIO_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_LOG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LOG = 2'd1;
  localparam logic [SRC_LOG_W-1:0] SRC_LOG_RST   = 3'd1;
  localparam logic [RATIO_W-1:0]   RATIO_LOG_RST = 2'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } gbu_state_t;

  // Tag that travels with each output point
  typedef struct packed {
    logic [GRID_W-1:0]  grid;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } gbu_meta_t;

endpackage

>>> design/gbu_in_if.sv
interface gbu_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gbu_pkg::FIELD_W-1:0] in_x;
  logic signed [gbu_pkg::FIELD_W-1:0] in_y;
  logic signed [gbu_pkg::FIELD_W-1:0] in_z;
  logic [gbu_pkg::GRID_W-1:0]         grid_id;

  modport source (output valid, in_x, in_y, in_z, grid_id, input ready);
  modport sink   (input valid, in_x, in_y, in_z, grid_id, output ready);
endinterface

>>> design/gbu_out_if.sv
interface gbu_out_if;
  logic                               valid;
  logic                               ready;
  logic [gbu_pkg::GRID_W-1:0]         out_grid;
  logic [gbu_pkg::COORD_W-1:0]        col;
  logic [gbu_pkg::COORD_W-1:0]        row;
  logic signed [gbu_pkg::FIELD_W-1:0] out_x;
  logic signed [gbu_pkg::FIELD_W-1:0] out_y;
  logic signed [gbu_pkg::FIELD_W-1:0] out_z;
  logic                               run_end;

  modport source (output valid, out_grid, col, row, out_x, out_y, out_z, run_end,
                  input ready);
  modport sink   (input valid, out_grid, col, row, out_x, out_y, out_z, run_end,
                  output ready);
endinterface

>>> design/gbu_ram.sv
module gbu_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/gbu_ctrl.sv
module gbu_ctrl #(
  parameter int MAX_SRC_LOG   = gbu_pkg::MAX_SRC_LOG,
  parameter int MAX_RATIO_LOG = gbu_pkg::MAX_RATIO_LOG,
  parameter int VALUE_WIDTH   = gbu_pkg::VALUE_WIDTH,
  localparam int PSW = MAX_SRC_LOG + 1,
  localparam int TW  = MAX_RATIO_LOG + 1,
  localparam int VW3 = 3 * VALUE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gbu_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gbu_pkg::CFG_DATA_W-1:0]   cfg_data,
  gbu_in_if.sink                           in_bus,
  // row store access
  output logic                             ram_re,
  output logic [PSW-1:0]                   ram_raddr,
  input  logic [VW3-1:0]                   ram_rdata,
  output logic                             ram_we,
  output logic [PSW-1:0]                   ram_waddr,
  output logic [VW3-1:0]                   ram_wdata,
  // point issue toward the blend pipeline
  output logic                             iss_valid,
  input  logic                             iss_ready,
  output logic [TW-1:0]                    iss_tx,
  output logic [TW-1:0]                    iss_ty,
  output gbu_pkg::gbu_meta_t               iss_meta,
  output logic [VW3-1:0]                   v00,
  output logic [VW3-1:0]                   v10,
  output logic [VW3-1:0]                   v01,
  output logic [VW3-1:0]                   v11,
  output logic [gbu_pkg::RATIO_W-1:0]      rl_eff
);

  localparam int SLW = $clog2(MAX_SRC_LOG + 1);
  localparam int BW  = PSW + MAX_RATIO_LOG + gbu_pkg::COORD_W;
  localparam int VW  = VALUE_WIDTH;

  gbu_pkg::gbu_state_t state_r, state_nxt;

  logic [gbu_pkg::SRC_LOG_W-1:0] src_log_r;
  logic [gbu_pkg::RATIO_W-1:0]   ratio_log_r;
  logic [PSW-1:0]                col_pos_r, row_pos_r;
  logic [PSW-1:0]                col_pos_nxt, row_pos_nxt;

  logic [SLW-1:0]  sl_eff;
  logic [PSW-1:0]  last_pos;
  logic [PSW-1:0]  c_eff, r_eff;
  logic [TW-1:0]   r_val;
  logic            in_fire;
  logic            wrap;
  logic            issue_last;

  // per-item job registers
  logic [VW3-1:0]                cur_r;
  logic [gbu_pkg::GRID_W-1:0]    grid_r;
  logic [PSW-1:0]                c_r;
  logic                          emit_r;
  logic [TW-1:0]                 xlim_r, ylim_r;
  logic [gbu_pkg::COORD_W-1:0]   base_col_r, base_row_r;
  logic [BW-1:0]                 base_col_w, base_row_w;
  logic [TW-1:0]                 tx_r, ty_r;

  // neighbor and operand registers
  logic [VW3-1:0] above_left_r, cur_left_r;
  logic [VW3-1:0] v00_r, v10_r, v01_r, v11_r;

  // Saturate the registers to their legal ranges
  always_comb begin
    if (src_log_r == '0) begin
      sl_eff = SLW'(1);
    end else if (32'(src_log_r) > MAX_SRC_LOG) begin
      sl_eff = SLW'(MAX_SRC_LOG);
    end else begin
      sl_eff = SLW'(src_log_r);
    end
    if (32'(ratio_log_r) > MAX_RATIO_LOG) begin
      rl_eff = gbu_pkg::RATIO_W'(MAX_RATIO_LOG);
    end else begin
      rl_eff = ratio_log_r;
    end
  end

  assign last_pos = PSW'(1) << sl_eff;
  assign r_val    = TW'(1) << rl_eff;
  assign wrap     = (col_pos_r > last_pos) || (row_pos_r > last_pos);
  assign c_eff    = wrap ? '0 : col_pos_r;
  assign r_eff    = wrap ? '0 : row_pos_r;
  assign in_fire  = in_bus.valid && in_bus.ready;

  assign base_col_w = BW'(c_eff - PSW'(1)) << rl_eff;
  assign base_row_w = BW'(r_eff - PSW'(1)) << rl_eff;

  // Advance the source position past the accepted point
  always_comb begin
    if (c_eff == last_pos) begin
      col_pos_nxt = '0;
      row_pos_nxt = (r_eff == last_pos) ? '0 : r_eff + PSW'(1);
    end else begin
      col_pos_nxt = c_eff + PSW'(1);
      row_pos_nxt = r_eff;
    end
  end

  // Configuration registers and source position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_log_r   <= gbu_pkg::SRC_LOG_RST;
      ratio_log_r <= gbu_pkg::RATIO_LOG_RST;
      col_pos_r   <= '0;
      row_pos_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == gbu_pkg::CFG_SRC_LOG) begin
        src_log_r <= cfg_data;
        col_pos_r <= '0;
        row_pos_r <= '0;
      end else if (cfg_idx == gbu_pkg::CFG_RATIO_LOG) begin
        ratio_log_r <= cfg_data[gbu_pkg::RATIO_W-1:0];
        col_pos_r   <= '0;
        row_pos_r   <= '0;
      end
    end else if (in_fire) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  assign issue_last = (tx_r == xlim_r) && (ty_r == ylim_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbu_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = gbu_pkg::ST_READ;
        end
      end
      gbu_pkg::ST_READ: begin
        state_nxt = emit_r ? gbu_pkg::ST_EMIT : gbu_pkg::ST_IDLE;
      end
      gbu_pkg::ST_EMIT: begin
        if (iss_ready && issue_last) begin
          state_nxt = gbu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbu_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_bus.ready = 1'b0;
    ram_we       = 1'b0;
    iss_valid    = 1'b0;
    unique case (state_r)
      gbu_pkg::ST_IDLE: in_bus.ready = 1'b1;
      gbu_pkg::ST_READ: ram_we       = 1'b1;
      gbu_pkg::ST_EMIT: iss_valid    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the beat and the cell geometry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_r      <= {in_bus.in_z[VW-1:0], in_bus.in_y[VW-1:0], in_bus.in_x[VW-1:0]};
      grid_r     <= in_bus.grid_id;
      c_r        <= c_eff;
      xlim_r     <= (c_eff == last_pos) ? r_val : r_val - TW'(1);
      ylim_r     <= (r_eff == last_pos) ? r_val : r_val - TW'(1);
      base_col_r <= base_col_w[gbu_pkg::COORD_W-1:0];
      base_row_r <= base_row_w[gbu_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else if (in_fire) begin
      emit_r <= (c_eff != '0) && (r_eff != '0);
    end
  end

  // Latch the four corners, then shift the neighbors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_left_r <= '0;
      cur_left_r   <= '0;
    end else if (state_r == gbu_pkg::ST_READ) begin
      above_left_r <= ram_rdata;
      cur_left_r   <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gbu_pkg::ST_READ) begin
      v00_r <= above_left_r;
      v10_r <= ram_rdata;
      v01_r <= cur_left_r;
      v11_r <= cur_r;
    end
  end

  // Step through the output points of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r <= '0;
      ty_r <= '0;
    end else if (state_r == gbu_pkg::ST_READ) begin
      tx_r <= '0;
      ty_r <= '0;
    end else if (state_r == gbu_pkg::ST_EMIT && iss_ready) begin
      if (tx_r == xlim_r) begin
        tx_r <= '0;
        ty_r <= ty_r + TW'(1);
      end else begin
        tx_r <= tx_r + TW'(1);
      end
    end
  end

  assign ram_re    = in_fire;
  assign ram_raddr = c_eff;
  assign ram_waddr = c_r;
  assign ram_wdata = cur_r;

  assign iss_tx        = tx_r;
  assign iss_ty        = ty_r;
  assign iss_meta.grid = grid_r;
  assign iss_meta.col  = base_col_r + gbu_pkg::COORD_W'(tx_r);
  assign iss_meta.row  = base_row_r + gbu_pkg::COORD_W'(ty_r);
  assign iss_meta.last = issue_last;
  assign v00 = v00_r;
  assign v10 = v10_r;
  assign v01 = v01_r;
  assign v11 = v11_r;

  // An accepted beat always goes to the memory read
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == gbu_pkg::ST_READ)
    else $error("accepted beat did not start a row store read");

  // The point counters stay inside the cell
  a_tile_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gbu_pkg::ST_EMIT |-> tx_r <= xlim_r && ty_r <= ylim_r)
    else $error("cell point counter out of range");

  // Only a cell-closing beat issues points
  a_emit_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gbu_pkg::ST_READ && !emit_r |=> state_r == gbu_pkg::ST_IDLE)
    else $error("points issued for a beat that closes no cell");

endmodule

>>> design/gbu_blend.sv
module gbu_blend #(
  parameter int MAX_RATIO_LOG = gbu_pkg::MAX_RATIO_LOG,
  parameter int VALUE_WIDTH   = gbu_pkg::VALUE_WIDTH,
  localparam int TW  = MAX_RATIO_LOG + 1,
  localparam int VW3 = 3 * VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        iss_valid,
  output logic                        iss_ready,
  input  logic [TW-1:0]               iss_tx,
  input  logic [TW-1:0]               iss_ty,
  input  gbu_pkg::gbu_meta_t          iss_meta,
  input  logic [VW3-1:0]              v00,
  input  logic [VW3-1:0]              v10,
  input  logic [VW3-1:0]              v01,
  input  logic [VW3-1:0]              v11,
  input  logic [gbu_pkg::RATIO_W-1:0] rl_eff,
  gbu_out_if.source                   out_bus
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + TW;
  localparam int SW = VW + 2 * TW;

  logic          adv;
  logic [TW-1:0] r_val, wx0, wy0;
  logic [SW-1:0] half;

  logic [VW-1:0] u00 [3];
  logic [VW-1:0] u10 [3];
  logic [VW-1:0] u01 [3];
  logic [VW-1:0] u11 [3];
  logic [PW-1:0] top_c [3];
  logic [PW-1:0] bot_c [3];
  logic [SW-1:0] sum_c [3];
  logic [SW-1:0] q_c   [3];
  logic [VW-1:0] res_c [3];

  logic               s1_valid_r;
  logic [PW-1:0]      s1_top_r [3];
  logic [PW-1:0]      s1_bot_r [3];
  logic [TW-1:0]      s1_ty_r;
  gbu_pkg::gbu_meta_t s1_meta_r;

  logic                              out_valid_r;
  gbu_pkg::gbu_meta_t                out_meta_r;
  logic signed [gbu_pkg::FIELD_W-1:0] out_val_r [3];

  // Whole pipeline moves when the output register is empty or being taken
  assign adv       = !out_valid_r || out_bus.ready;
  assign iss_ready = adv;

  assign r_val = TW'(1) << rl_eff;
  assign wx0   = r_val - iss_tx;
  assign wy0   = r_val - s1_ty_r;
  assign half  = (SW'(1) << {rl_eff, 1'b0}) >> 1;

  // Horizontal blend on biased values
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u00[k]   = v00[k*VW +: VW] ^ {1'b1, {(VW-1){1'b0}}};
      u10[k]   = v10[k*VW +: VW] ^ {1'b1, {(VW-1){1'b0}}};
      u01[k]   = v01[k*VW +: VW] ^ {1'b1, {(VW-1){1'b0}}};
      u11[k]   = v11[k*VW +: VW] ^ {1'b1, {(VW-1){1'b0}}};
      top_c[k] = PW'(wx0) * PW'(u00[k]) + PW'(iss_tx) * PW'(u10[k]);
      bot_c[k] = PW'(wx0) * PW'(u01[k]) + PW'(iss_tx) * PW'(u11[k]);
    end
  end

  // Vertical blend, round half up, drop the bias
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = SW'(wy0) * SW'(s1_top_r[k]) + SW'(s1_ty_r) * SW'(s1_bot_r[k]) + half;
      q_c[k]   = sum_c[k] >> {rl_eff, 1'b0};
      res_c[k] = q_c[k][VW-1:0] ^ {1'b1, {(VW-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= iss_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (adv && iss_valid) begin
      for (int k = 0; k < 3; k++) begin
        s1_top_r[k] <= top_c[k];
        s1_bot_r[k] <= bot_c[k];
      end
      s1_ty_r   <= iss_ty;
      s1_meta_r <= iss_meta;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        out_val_r[k] <= gbu_pkg::FIELD_W'(signed'(res_c[k]));
      end
      out_meta_r <= s1_meta_r;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.out_grid = out_meta_r.grid;
  assign out_bus.col      = out_meta_r.col;
  assign out_bus.row      = out_meta_r.row;
  assign out_bus.out_x    = out_val_r[0];
  assign out_bus.out_y    = out_val_r[1];
  assign out_bus.out_z    = out_val_r[2];
  assign out_bus.run_end  = out_meta_r.last;

  // A result only appears after a full first stage
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output beat without a stage one entry");

  // A stalled first stage keeps its point
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_meta_r))
    else $error("stage one lost its point under a stall");

endmodule

>>> design/grid_bilinear_upsampler.sv
// Bilinear grid upsampler. Source points of square grids (2^src_log+1 per
// side) arrive in raster order; each point that closes a cell releases all
// output points of that cell, 2^ratio_log by 2^ratio_log, plus the last
// output column or row at the far edges, each tagged with its output column
// and row and the grid index. Values are signed fixed point, blended exactly
// and rounded half up. An accepted beat first reads the row store, then
// releases one result per cycle, unless the output stalls, through a
// two-stage blend pipeline. No new point is taken until every result of
// the current one has been issued. A write to either register returns
// the position to the first point of a grid; write only while the block is
// idle.
module grid_bilinear_upsampler #(
  parameter int MAX_SRC_LOG   = gbu_pkg::MAX_SRC_LOG,
  parameter int MAX_RATIO_LOG = gbu_pkg::MAX_RATIO_LOG,
  parameter int VALUE_WIDTH   = gbu_pkg::VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gbu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gbu_pkg::CFG_DATA_W-1:0] cfg_data,
  gbu_in_if.sink                         in_bus,
  gbu_out_if.source                      out_bus
);

  localparam int PSW   = MAX_SRC_LOG + 1;
  localparam int TW    = MAX_RATIO_LOG + 1;
  localparam int VW3   = 3 * VALUE_WIDTH;
  localparam int DEPTH = (1 << MAX_SRC_LOG) + 1;

  logic                        ram_re, ram_we;
  logic [PSW-1:0]              ram_raddr, ram_waddr;
  logic [VW3-1:0]              ram_rdata, ram_wdata;
  logic                        iss_valid, iss_ready;
  logic [TW-1:0]               iss_tx, iss_ty;
  gbu_pkg::gbu_meta_t          iss_meta;
  logic [VW3-1:0]              v00, v10, v01, v11;
  logic [gbu_pkg::RATIO_W-1:0] rl_eff;

  // Previous source row
  gbu_ram #(
    .WIDTH (VW3),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbu_ctrl #(
    .MAX_SRC_LOG   (MAX_SRC_LOG),
    .MAX_RATIO_LOG (MAX_RATIO_LOG),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_tx    (iss_tx),
    .iss_ty    (iss_ty),
    .iss_meta  (iss_meta),
    .v00       (v00),
    .v10       (v10),
    .v01       (v01),
    .v11       (v11),
    .rl_eff    (rl_eff)
  );

  gbu_blend #(
    .MAX_RATIO_LOG (MAX_RATIO_LOG),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss_tx    (iss_tx),
    .iss_ty    (iss_ty),
    .iss_meta  (iss_meta),
    .v00       (v00),
    .v10       (v10),
    .v01       (v01),
    .v11       (v11),
    .rl_eff    (rl_eff),
    .out_bus   (out_bus)
  );

endmodule

>>> test/grid_bilinear_upsampler_test.sv
`timescale 1ns / 1ps
module grid_bilinear_upsampler_test;

  localparam int ITEM_TARGET    = 370;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ROW_DEPTH      = (1 << gbu_pkg::MAX_SRC_LOG) + 1;

  // Indexes outside the register map, written to check they are ignored
  localparam logic [gbu_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [gbu_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic signed [gbu_pkg::FIELD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [gbu_pkg::FIELD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [gbu_pkg::FIELD_W-1:0] x;
    logic signed [gbu_pkg::FIELD_W-1:0] y;
    logic signed [gbu_pkg::FIELD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t                      v;
    logic [gbu_pkg::GRID_W-1:0] grid;
  } src_point_t;

  typedef struct packed {
    logic [gbu_pkg::GRID_W-1:0]  grid;
    logic [gbu_pkg::COORD_W-1:0] col;
    logic [gbu_pkg::COORD_W-1:0] row;
    vec3_t                       v;
    logic                        last;
  } up_point_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [gbu_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [gbu_pkg::CFG_DATA_W-1:0] cfg_data;

  gbu_in_if  in_bus ();
  gbu_out_if out_bus ();

  grid_bilinear_upsampler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #2 clk = ~clk;

  // Shadow of the block: registers, position, previous row and neighbours
  logic [gbu_pkg::SRC_LOG_W-1:0] model_src_log   = gbu_pkg::SRC_LOG_RST;
  logic [gbu_pkg::RATIO_W-1:0]   model_ratio_log = gbu_pkg::RATIO_LOG_RST;
  int                   pos_col = 0;
  int                   pos_row = 0;
  vec3_t                prev_row [ROW_DEPTH];
  vec3_t                upper_left = '0;
  vec3_t                left_pt    = '0;

  src_point_t queued_points [$];
  up_point_t  awaited_outputs [$];
  int         points_queued = 0;
  int         points_taken  = 0;
  int         outputs_seen  = 0;
  int         fail_count    = 0;
  int         idle_cycles   = 0;
  logic       in_beat       = 1'b0;
  int         burst_left    = 0;
  int         gap_left      = 0;
  rx_mode_t   rx_mode       = RX_OPEN;
  int         rx_left       = 0;

  function automatic int grid_side(logic [gbu_pkg::SRC_LOG_W-1:0] sl);
    int s;
    s = int'(sl);
    if (s < 1) s = 1;
    if (s > gbu_pkg::MAX_SRC_LOG) s = gbu_pkg::MAX_SRC_LOG;
    return (1 << s) + 1;
  endfunction

  function automatic logic signed [gbu_pkg::FIELD_W-1:0] edge_value(int k);
    case (k % 5)
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic signed [gbu_pkg::FIELD_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Exact weighted sum of the four corners, floor-divided by R*R after adding R*R/2
  function automatic logic signed [gbu_pkg::FIELD_W-1:0] blend_q16(
    input logic signed [gbu_pkg::FIELD_W-1:0] v00, v10, v01, v11,
    input int tx, ty, rl
  );
    longint a00, a10, a01, a11, r, wx, wy, acc;
    a00 = longint'(v00);
    a10 = longint'(v10);
    a01 = longint'(v01);
    a11 = longint'(v11);
    wx  = longint'(tx);
    wy  = longint'(ty);
    r   = longint'(1) << rl;
    acc = (r - wy) * ((r - wx) * a00 + wx * a10)
        + wy * ((r - wx) * a01 + wx * a11) + (r * r) / 2;
    return gbu_pkg::FIELD_W'(acc >>> (2 * rl));
  endfunction

  // Queue every output point that this source point releases, then advance
  task automatic interpolate_cell(src_point_t p);
    int side, rl, r, c, rw, xlim, ylim, tx, ty;
    up_point_t e;
    rl   = (int'(model_ratio_log) > gbu_pkg::MAX_RATIO_LOG) ?
           gbu_pkg::MAX_RATIO_LOG : int'(model_ratio_log);
    r    = 1 << rl;
    side = grid_side(model_src_log);
    c    = pos_col;
    rw   = pos_row;
    if (c >= side || rw >= side) begin
      c  = 0;
      rw = 0;
    end
    if (c > 0 && rw > 0) begin
      xlim = (c == side - 1) ? r : r - 1;
      ylim = (rw == side - 1) ? r : r - 1;
      for (ty = 0; ty <= ylim; ty++) begin
        for (tx = 0; tx <= xlim; tx++) begin
          e.grid = p.grid;
          e.col  = gbu_pkg::COORD_W'((c - 1) * r + tx);
          e.row  = gbu_pkg::COORD_W'((rw - 1) * r + ty);
          e.v.x  = blend_q16(upper_left.x, prev_row[c].x, left_pt.x, p.v.x, tx, ty, rl);
          e.v.y  = blend_q16(upper_left.y, prev_row[c].y, left_pt.y, p.v.y, tx, ty, rl);
          e.v.z  = blend_q16(upper_left.z, prev_row[c].z, left_pt.z, p.v.z, tx, ty, rl);
          e.last = (tx == xlim && ty == ylim);
          awaited_outputs.push_back(e);
        end
      end
    end
    upper_left  = prev_row[c];
    prev_row[c] = p.v;
    left_pt     = p.v;
    c++;
    if (c >= side) begin
      c = 0;
      rw++;
      if (rw >= side) rw = 0;
    end
    pos_col = c;
    pos_row = rw;
  endtask

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                outputs_seen, name, got, want));
  endtask

  task automatic write_reg(logic [gbu_pkg::CFG_IDX_W-1:0] idx,
                           logic [gbu_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      gbu_pkg::CFG_SRC_LOG: begin
        model_src_log = data;
        pos_col = 0;
        pos_row = 0;
      end
      gbu_pkg::CFG_RATIO_LOG: begin
        model_ratio_log = gbu_pkg::RATIO_W'(data);
        pos_col = 0;
        pos_row = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_point(src_point_t p);
    queued_points.push_back(p);
    points_queued++;
  endtask

  // Random points; new grid tag per grid, with a stray tag now and then
  task automatic push_points(int n);
    src_point_t p;
    int per_grid, k;
    logic [gbu_pkg::GRID_W-1:0] tag;
    per_grid = grid_side(model_src_log) * grid_side(model_src_log);
    tag = gbu_pkg::GRID_W'($urandom);
    for (k = 0; k < n; k++) begin
      if (k != 0 && k % per_grid == 0) tag = gbu_pkg::GRID_W'($urandom);
      p.v.x  = rand_value();
      p.v.y  = rand_value();
      p.v.z  = rand_value();
      p.grid = ($urandom_range(0, 15) == 0) ? gbu_pkg::GRID_W'($urandom) : tag;
      push_point(p);
    end
  endtask

  // Hold until every point is taken and every result is back, then let the block settle
  task automatic drain();
    while (points_taken != points_queued || awaited_outputs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of random length, each followed by a random gap that may be empty
  always @(negedge clk) begin
    src_point_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_beat) begin
      if (gap_left > 0 || queued_points.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_bus.valid <= 1'b0;
      end else begin
        nxt = queued_points.pop_front();
        in_bus.valid   <= 1'b1;
        in_bus.in_x    <= nxt.v.x;
        in_bus.in_y    <= nxt.v.y;
        in_bus.in_z    <= nxt.v.z;
        in_bus.grid_id <= nxt.grid;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: switch between open, choppy and mostly stalled stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_CHOPPY: out_bus.ready <= 1'($urandom_range(0, 1));
        default:   out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check results against the oldest expectation, then predict from new input beats
  always @(posedge clk) begin
    src_point_t p;
    up_point_t  want;
    logic       got_in, got_out;
    if (!rst_n) begin
      in_beat <= 1'b0;
    end else begin
      got_in  = in_bus.valid && in_bus.ready;
      got_out = out_bus.valid && out_bus.ready;
      in_beat <= got_in;
      if (got_out) begin
        if (awaited_outputs.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected (col %0d row %0d)",
                                    outputs_seen, out_bus.col, out_bus.row));
        end else begin
          want = awaited_outputs.pop_front();
          check_field("out_grid", 32'(out_bus.out_grid), 32'(want.grid));
          check_field("col", 32'(out_bus.col), 32'(want.col));
          check_field("row", 32'(out_bus.row), 32'(want.row));
          check_field("out_x", out_bus.out_x, want.v.x);
          check_field("out_y", out_bus.out_y, want.v.y);
          check_field("out_z", out_bus.out_z, want.v.z);
          check_field("run_end", 32'(out_bus.run_end), 32'(want.last));
        end
        outputs_seen++;
      end
      if (got_in) begin
        p.v.x  = in_bus.in_x;
        p.v.y  = in_bus.in_y;
        p.v.z  = in_bus.in_z;
        p.grid = in_bus.grid_id;
        interpolate_cell(p);
        points_taken++;
      end
      if (got_in || got_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** grid_bilinear_upsampler: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    src_point_t p;
    int i, n, side;
    for (i = 0; i < ROW_DEPTH; i++) prev_row[i] = '0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = gbu_pkg::CFG_SRC_LOG;
    cfg_data       = '0;
    in_bus.valid   = 1'b0;
    in_bus.in_x    = '0;
    in_bus.in_y    = '0;
    in_bus.in_z    = '0;
    in_bus.grid_id = '0;
    out_bus.ready  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: 3x3 grid at ratio two, full-scale swings and half-way rounding
    for (i = 0; i < 9; i++) begin
      p.v.x  = i[0] ? Q_MAX : Q_MIN;
      p.v.y  = i - 4;
      p.v.z  = edge_value(i + 1);
      p.grid = '1;
      push_point(p);
    end
    drain();

    // Copy mode, source size below range, spare index ignored
    write_reg(gbu_pkg::CFG_SRC_LOG, 3'd0);
    write_reg(gbu_pkg::CFG_RATIO_LOG, 3'd0);
    write_reg(CFG_SPARE_A, '1);
    for (i = 0; i < 9; i++) begin
      p.v.x  = edge_value(i);
      p.v.y  = edge_value(i + 2);
      p.v.z  = $urandom;
      p.grid = '0;
      push_point(p);
    end
    drain();

    // Largest grid and ratio, both above range: two rows reach the far column
    write_reg(gbu_pkg::CFG_SRC_LOG, 3'd7);
    write_reg(gbu_pkg::CFG_RATIO_LOG, 3'd3);
    write_reg(CFG_SPARE_B, 3'd5);
    push_points(2 * grid_side(model_src_log) + 5);
    drain();

    // Random settings: whole grids at small sizes, partial rows at large ones
    while (points_queued < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(gbu_pkg::CFG_SRC_LOG, gbu_pkg::CFG_DATA_W'($urandom_range(0, 5)));
      if ($urandom_range(0, 3) != 0)
        write_reg(gbu_pkg::CFG_RATIO_LOG, gbu_pkg::CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  gbu_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      side = grid_side(model_src_log);
      if (side > 9) begin
        n = 2 * side + $urandom_range(1, side);
      end else begin
        n = side * side * $urandom_range(1, 2);
        if ($urandom_range(0, 2) == 0) n += $urandom_range(1, side + 2);
      end
      // Trim the last batch to the item budget
      if (n > ITEM_TARGET - points_queued) n = ITEM_TARGET - points_queued;
      push_points(n);
      drain();
    end

    if (fail_count == 0) begin
      $display("** grid_bilinear_upsampler: PASSED **");
    end else begin
      $display("** grid_bilinear_upsampler: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/gbu_pkg.sv
design/gbu_in_if.sv
design/gbu_out_if.sv
design/gbu_ram.sv
design/gbu_ctrl.sv
design/gbu_blend.sv
design/grid_bilinear_upsampler.sv
test/grid_bilinear_upsampler_test.sv
